// ===== sv/fosp_pkg.sv =====
// ----------------------------------------------------------------------------
// fosp_pkg
// Shared types and character codes for the format spec option parser.
// ----------------------------------------------------------------------------
package fosp_pkg;

    // Parser phases.
    localparam logic [2:0] PH_FLAGS   = 3'd0;
    localparam logic [2:0] PH_WDIG    = 3'd1;
    localparam logic [2:0] PH_AFTER_W = 3'd2;
    localparam logic [2:0] PH_PSTART  = 3'd3;
    localparam logic [2:0] PH_PDIG    = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd7;

    // Characters of the spec grammar.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam int unsigned RADIX = 10;

    localparam int unsigned FIELD_BITS = 16;

    typedef struct packed {
        logic zero;
        logic hash;
        logic space;
        logic plus;
        logic minus;
    } flags_t;

    typedef struct packed {
        logic [7:0]         ch;
        logic signed [31:0] star_argument;
        logic               start_req;
    } in_t;

    typedef struct packed {
        logic                  consumed;
        logic                  done_res;
        logic                  minus_flag;
        logic                  plus_flag;
        logic                  space_flag;
        logic                  hash_flag;
        logic                  zero_flag;
        logic [FIELD_BITS-1:0] width;
        logic                  width_given;
        logic [FIELD_BITS-1:0] precision;
        logic                  precision_given;
        logic                  formatting_required;
    } out_t;

endpackage

// ===== sv/fosp_accum.sv =====
// ----------------------------------------------------------------------------
// fosp_accum
// Decimal accumulate step: acc * 10 + digit, saturated at the value maximum.
// ----------------------------------------------------------------------------
module fosp_accum #(
    parameter int VALUE_BITS = 16
) (
    input  logic [VALUE_BITS-1:0] acc,
    input  logic [3:0]            digit,
    output logic [VALUE_BITS-1:0] result
);
    import fosp_pkg::*;

    logic [VALUE_BITS+3:0] acc_ext;
    logic [VALUE_BITS+3:0] sum;

    // The product by ten is built from two shifts; the sum always fits in
    // four extra bits, so any bit above the value width means overflow.
    assign acc_ext = {4'b0000, acc};
    assign sum = (acc_ext << 3) + (acc_ext << 1) + {{VALUE_BITS{1'b0}}, digit};

    always_comb
    begin
        if (sum[VALUE_BITS+3:VALUE_BITS] != 4'b0000)
        begin
            result = {VALUE_BITS{1'b1}};
        end
        else
        begin
            result = sum[VALUE_BITS-1:0];
        end
    end

endmodule

// ===== sv/fosp_decode.sv =====
// ----------------------------------------------------------------------------
// fosp_decode
// One character step of the option grammar: next parser state and result.
// ----------------------------------------------------------------------------
module fosp_decode #(
    parameter int VALUE_BITS = 16
) (
    input  fosp_pkg::in_t          item,
    input  logic [2:0]             phase,
    input  fosp_pkg::flags_t       flags,
    input  logic [VALUE_BITS-1:0]  width_value,
    input  logic                   width_seen,
    input  logic [VALUE_BITS-1:0]  prec_value,
    input  logic                   prec_seen,
    input  logic                   prec_negative,
    output logic [2:0]             phase_next,
    output fosp_pkg::flags_t       flags_next,
    output logic [VALUE_BITS-1:0]  width_value_next,
    output logic                   width_seen_next,
    output logic [VALUE_BITS-1:0]  prec_value_next,
    output logic                   prec_seen_next,
    output logic                   prec_negative_next,
    output fosp_pkg::out_t         result
);
    import fosp_pkg::*;

    localparam logic [31:0] VALUE_MAX32 = 32'((64'd1 << VALUE_BITS) - 64'd1);

    logic [2:0]            e_phase;
    flags_t                e_flags;
    logic [VALUE_BITS-1:0] e_width;
    logic                  e_wseen;
    logic [VALUE_BITS-1:0] e_prec;
    logic                  e_pseen;
    logic                  e_pneg;

    logic                  is_digit;
    logic                  arg_negative;
    logic [31:0]           arg_mag;
    logic [VALUE_BITS-1:0] mag_sat;
    logic [VALUE_BITS-1:0] arg_sat;
    logic [VALUE_BITS-1:0] acc_in;
    logic [VALUE_BITS-1:0] acc_out;
    logic                  consumed;
    logic                  to_after;
    logic                  pgiven;
    logic [VALUE_BITS+FIELD_BITS-1:0] width_ext;
    logic [VALUE_BITS+FIELD_BITS-1:0] prec_ext;

    // A start mark restores the defaults before the character is looked at.
    always_comb
    begin
        if (item.start_req)
        begin
            e_phase = PH_FLAGS;
            e_flags = '0;
            e_width = '0;
            e_wseen = 1'b0;
            e_prec  = '0;
            e_pseen = 1'b0;
            e_pneg  = 1'b0;
        end
        else
        begin
            e_phase = phase;
            e_flags = flags;
            e_width = width_value;
            e_wseen = width_seen;
            e_prec  = prec_value;
            e_pseen = prec_seen;
            e_pneg  = prec_negative;
        end
    end

    assign is_digit = item.ch inside {[CH_ZERO:CH_NINE]};

    // The magnitude of the most negative argument is 2^31, which still fits
    // in 32 unsigned bits.
    assign arg_negative = item.star_argument[31];
    assign arg_mag = arg_negative ? (~item.star_argument + 32'd1) : item.star_argument;
    assign mag_sat = (arg_mag > VALUE_MAX32) ? {VALUE_BITS{1'b1}} : arg_mag[VALUE_BITS-1:0];
    assign arg_sat = mag_sat;

    always_comb
    begin
        case (e_phase)
            PH_WDIG: acc_in = e_width;
            PH_PDIG: acc_in = e_prec;
            default: acc_in = '0;
        endcase
    end

    fosp_accum #(
        .VALUE_BITS(VALUE_BITS)
    ) u_accum (
        .acc    (acc_in),
        .digit  (item.ch[3:0]),
        .result (acc_out)
    );

    always_comb
    begin
        phase_next         = e_phase;
        flags_next         = e_flags;
        width_value_next   = e_width;
        width_seen_next    = e_wseen;
        prec_value_next    = e_prec;
        prec_seen_next     = e_pseen;
        prec_negative_next = e_pneg;
        consumed           = 1'b0;
        to_after           = 1'b0;

        case (e_phase)
            PH_FLAGS:
            begin
                consumed = 1'b1;
                case (item.ch)
                    CH_MINUS: flags_next.minus = 1'b1;
                    CH_PLUS:  flags_next.plus  = 1'b1;
                    CH_SPACE: flags_next.space = 1'b1;
                    CH_HASH:  flags_next.hash  = 1'b1;
                    CH_ZERO:  flags_next.zero  = 1'b1;
                    CH_STAR:
                    begin
                        width_value_next = arg_sat;
                        width_seen_next  = 1'b1;
                        phase_next       = PH_AFTER_W;
                        if (arg_negative)
                        begin
                            flags_next.minus = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (is_digit)
                        begin
                            width_value_next = acc_out;
                            width_seen_next  = 1'b1;
                            phase_next       = PH_WDIG;
                        end
                        else
                        begin
                            consumed = 1'b0;
                            to_after = 1'b1;
                        end
                    end
                endcase
            end
            PH_WDIG:
            begin
                if (is_digit)
                begin
                    width_value_next = acc_out;
                    consumed         = 1'b1;
                end
                else
                begin
                    to_after = 1'b1;
                end
            end
            PH_AFTER_W:
            begin
                to_after = 1'b1;
            end
            PH_PSTART:
            begin
                consumed = 1'b1;
                if (item.ch == CH_STAR)
                begin
                    prec_value_next    = arg_negative ? '0 : arg_sat;
                    prec_seen_next     = ~arg_negative;
                    prec_negative_next = 1'b0;
                    phase_next         = PH_DONE;
                end
                else if (item.ch == CH_MINUS)
                begin
                    prec_negative_next = 1'b1;
                    phase_next         = PH_PDIG;
                end
                else if (is_digit)
                begin
                    prec_value_next = acc_out;
                    phase_next      = PH_PDIG;
                end
                else
                begin
                    consumed   = 1'b0;
                    phase_next = PH_DONE;
                end
            end
            PH_PDIG:
            begin
                if (is_digit)
                begin
                    prec_value_next = acc_out;
                    consumed        = 1'b1;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // Anything that does not continue the flags or the width digits is
        // looked at as the optional dot.
        if (to_after)
        begin
            if (item.ch == CH_DOT)
            begin
                prec_value_next    = '0;
                prec_seen_next     = 1'b1;
                prec_negative_next = 1'b0;
                phase_next         = PH_PSTART;
                consumed           = 1'b1;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end
    end

    // A minus sign only cancels the precision once a nonzero digit follows.
    assign pgiven = prec_seen_next && !(prec_negative_next && (prec_value_next != '0));

    assign width_ext = {{FIELD_BITS{1'b0}}, width_value_next};
    assign prec_ext  = {{FIELD_BITS{1'b0}}, prec_value_next};

    always_comb
    begin
        result.consumed            = consumed;
        result.done_res            = ~consumed;
        result.minus_flag          = flags_next.minus;
        result.plus_flag           = flags_next.plus;
        result.space_flag          = flags_next.space;
        result.hash_flag           = flags_next.hash;
        result.zero_flag           = flags_next.zero;
        result.width               = width_seen_next ? width_ext[FIELD_BITS-1:0] : '0;
        result.width_given         = width_seen_next;
        result.precision           = pgiven ? prec_ext[FIELD_BITS-1:0] : '0;
        result.precision_given     = pgiven;
        result.formatting_required = (flags_next != '0) || width_seen_next || pgiven;
    end

endmodule

// ===== sv/format_spec_option_parser_unit.sv =====
// ----------------------------------------------------------------------------
// format_spec_option_parser_unit
// Character-at-a-time parser of printf flags, width and precision.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_ready     fosp_pkg::in_t  (ch, argument, start)
// out       output     out_valid / out_ready   fosp_pkg::out_t (status and options)
//
// Each item passes the input register, where the decode and the
// multiply-by-ten accumulate run, and then the result register. One item
// is taken in every cycle while the output does not stall; the parser
// state is written as an item moves to the result register.
// Reset puts the parser in the flags phase with all options at defaults.
// A stall on the output holds both registers; the input stays ready while
// the input register is empty.
// ----------------------------------------------------------------------------
module format_spec_option_parser_unit #(
    parameter int VALUE_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fosp_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output fosp_pkg::out_t  out_data
);
    import fosp_pkg::*;

    logic                  in_valid_reg;
    in_t                   in_data_reg;
    logic                  out_valid_reg;
    out_t                  out_data_reg;

    logic [2:0]            phase_reg;
    flags_t                flags_reg;
    logic [VALUE_BITS-1:0] width_value_reg;
    logic                  width_seen_reg;
    logic [VALUE_BITS-1:0] prec_value_reg;
    logic                  prec_seen_reg;
    logic                  prec_negative_reg;

    logic [2:0]            phase_next;
    flags_t                flags_next;
    logic [VALUE_BITS-1:0] width_value_next;
    logic                  width_seen_next;
    logic [VALUE_BITS-1:0] prec_value_next;
    logic                  prec_seen_next;
    logic                  prec_negative_next;
    out_t                  result;

    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    fosp_decode #(
        .VALUE_BITS(VALUE_BITS)
    ) u_decode (
        .item               (in_data_reg),
        .phase              (phase_reg),
        .flags              (flags_reg),
        .width_value        (width_value_reg),
        .width_seen         (width_seen_reg),
        .prec_value         (prec_value_reg),
        .prec_seen          (prec_seen_reg),
        .prec_negative      (prec_negative_reg),
        .phase_next         (phase_next),
        .flags_next         (flags_next),
        .width_value_next   (width_value_next),
        .width_seen_next    (width_seen_next),
        .prec_value_next    (prec_value_next),
        .prec_seen_next     (prec_seen_next),
        .prec_negative_next (prec_negative_next),
        .result             (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            phase_reg         <= PH_FLAGS;
            flags_reg         <= '0;
            width_value_reg   <= '0;
            width_seen_reg    <= 1'b0;
            prec_value_reg    <= '0;
            prec_seen_reg     <= 1'b0;
            prec_negative_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                phase_reg         <= phase_next;
                flags_reg         <= flags_next;
                width_value_reg   <= width_value_next;
                width_seen_reg    <= width_seen_next;
                prec_value_reg    <= prec_value_next;
                prec_seen_reg     <= prec_seen_next;
                prec_negative_reg <= prec_negative_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== verif/format_spec_option_parser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// format_spec_option_parser_unit_tb
// Self-checking bench for the printf option parser. A short directed run of
// flags, widths and precisions is followed by random specs and noise. Items
// are offered in bursts while the result side stalls on its own pattern, and
// every result is checked field by field against a predictor of the parser.
// ----------------------------------------------------------------------------
module format_spec_option_parser_unit_tb;

    import fosp_pkg::*;

    localparam int              VALUE_BITS   = 16;
    localparam longint unsigned VALUE_MAX    = (64'd1 << VALUE_BITS) - 1;
    localparam int              RANDOM_ITEMS = 1100;
    localparam int              LONG_HOLD    = 60;
    localparam int              DRAIN_LIMIT  = 2000;

    typedef enum int { RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC } rx_pattern_t;

    class spec_scoreboard;
        logic [2:0]  phase;
        flags_t      flags;
        int unsigned width_val;
        bit          width_seen;
        int unsigned prec_val;
        bit          prec_seen;
        bit          prec_neg;
        out_t        pending_results[$];
        int          errors;

        function new();
            clear_options();
            errors = 0;
        endfunction

        function void clear_options();
            phase      = PH_FLAGS;
            flags      = '0;
            width_val  = 0;
            width_seen = 0;
            prec_val   = 0;
            prec_seen  = 0;
            prec_neg   = 0;
        endfunction

        function int unsigned saturate(longint unsigned v);
            return (v > VALUE_MAX) ? int'(VALUE_MAX) : int'(v);
        endfunction

        function int unsigned accumulate(int unsigned acc, logic [7:0] c);
            return saturate(longint'(acc) * RADIX + longint'(c - CH_ZERO));
        endfunction

        // Returns 1 when the character belongs to the spec, 0 when it ends it.
        function bit parse_char(logic [7:0] c, longint arg);
            logic [2:0] p;
            bit         is_dig;
            p = phase;
            is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
            if (p == PH_FLAGS)
            begin
                case (c)
                    CH_MINUS: flags.minus = 1'b1;
                    CH_PLUS:  flags.plus  = 1'b1;
                    CH_SPACE: flags.space = 1'b1;
                    CH_HASH:  flags.hash  = 1'b1;
                    CH_ZERO:  flags.zero  = 1'b1;
                    default:  ;
                endcase
                if (c inside {CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO})
                    return 1'b1;
                if (c == CH_STAR)
                begin
                    if (arg < 0)
                    begin
                        width_val   = saturate(longint'(-arg));
                        flags.minus = 1'b1;
                    end
                    else
                        width_val = saturate(arg);
                    width_seen = 1'b1;
                    phase = PH_AFTER_W;
                    return 1'b1;
                end
                if (is_dig)
                begin
                    width_val  = accumulate(0, c);
                    width_seen = 1'b1;
                    phase = PH_WDIG;
                    return 1'b1;
                end
                p = PH_AFTER_W;
            end
            else if (p == PH_WDIG)
            begin
                if (is_dig)
                begin
                    width_val = accumulate(width_val, c);
                    return 1'b1;
                end
                p = PH_AFTER_W;
            end

            if (p == PH_AFTER_W)
            begin
                if (c == CH_DOT)
                begin
                    prec_val  = 0;
                    prec_seen = 1'b1;
                    prec_neg  = 1'b0;
                    phase = PH_PSTART;
                    return 1'b1;
                end
            end
            else if (p == PH_PSTART)
            begin
                if (c == CH_STAR)
                begin
                    // A negative star precision counts as no precision at all.
                    prec_val  = (arg < 0) ? 0 : saturate(arg);
                    prec_seen = (arg >= 0);
                    prec_neg  = 1'b0;
                    phase = PH_DONE;
                    return 1'b1;
                end
                if (c == CH_MINUS)
                begin
                    prec_neg = 1'b1;
                    phase = PH_PDIG;
                    return 1'b1;
                end
                if (is_dig)
                begin
                    prec_val = accumulate(0, c);
                    phase = PH_PDIG;
                    return 1'b1;
                end
            end
            else if (p == PH_PDIG)
            begin
                if (is_dig)
                begin
                    prec_val = accumulate(prec_val, c);
                    return 1'b1;
                end
            end
            phase = PH_DONE;
            return 1'b0;
        endfunction

        function void note_input(in_t item);
            out_t res;
            bit   taken;
            bit   prec_given;
            if (item.start_req)
                clear_options();
            taken = parse_char(item.ch, longint'($signed(item.star_argument)));
            // A minus sign only cancels the precision when a nonzero digit follows it.
            prec_given = prec_seen && !(prec_neg && prec_val != 0);
            res.consumed            = taken;
            res.done_res            = !taken;
            res.minus_flag          = flags.minus;
            res.plus_flag           = flags.plus;
            res.space_flag          = flags.space;
            res.hash_flag           = flags.hash;
            res.zero_flag           = flags.zero;
            res.width               = width_seen ? 16'(width_val) : 16'd0;
            res.width_given         = width_seen;
            res.precision           = prec_given ? 16'(prec_val) : 16'd0;
            res.precision_given     = prec_given;
            res.formatting_required = (flags != '0) || width_seen || prec_given;
            pending_results.push_back(res);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("%0t ns mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v)
                report($sformatf("%s got %0d, expected %0d", name, got_v, want_v));
        endtask

        task check_result(out_t got);
            out_t want;
            if (pending_results.size() == 0)
            begin
                report("result arrived with no item pending");
                return;
            end
            want = pending_results.pop_front();
            compare_field("consumed", got.consumed, want.consumed);
            compare_field("done_res", got.done_res, want.done_res);
            compare_field("minus_flag", got.minus_flag, want.minus_flag);
            compare_field("plus_flag", got.plus_flag, want.plus_flag);
            compare_field("space_flag", got.space_flag, want.space_flag);
            compare_field("hash_flag", got.hash_flag, want.hash_flag);
            compare_field("zero_flag", got.zero_flag, want.zero_flag);
            compare_field("width", got.width, want.width);
            compare_field("width_given", got.width_given, want.width_given);
            compare_field("precision", got.precision, want.precision);
            compare_field("precision_given", got.precision_given, want.precision_given);
            compare_field("formatting_required", got.formatting_required,
                          want.formatting_required);
        endtask

        function int pending_count();
            return pending_results.size();
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    spec_scoreboard sb = new();

    in_t         spec_q[$];
    int          items_sent    = 0;
    int          burst_left    = 0;
    int          steady_items  = 0;
    bit          hold_request  = 1'b0;
    int          hold_left     = 0;
    rx_pattern_t rx_pattern    = RX_ALWAYS;
    int          rx_left       = 0;
    int          rx_cycle      = 0;

    format_spec_option_parser_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (in_valid && in_ready)
                sb.note_input(in_data);
        end
    end

    // The result side stalls on a pattern that changes now and then; a long
    // hold-off on request lets the parser fill up and push back.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 150);
            end
            rx_left--;
            case (rx_pattern)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= (rx_cycle % 5 != 0);
            endcase
        end
    end

    function automatic in_t make_item(logic [7:0] c, logic signed [31:0] arg, bit start);
        in_t item;
        item.ch            = c;
        item.star_argument = arg;
        item.start_req     = start;
        return item;
    endfunction

    function automatic logic signed [31:0] pick_argument();
        case ($urandom_range(0, 7))
            0:       return 32'sd0;
            1:       return -32'sd1;
            2:       return 32'sh8000_0000;
            3:       return 32'sh7FFF_FFFF;
            4:       return $urandom_range(0, 100);
            5:       return -$signed($urandom_range(1, 100));
            default: return $urandom;
        endcase
    endfunction

    // The first character of a spec carries the start mark.
    function automatic void add_char(logic [7:0] c, bit with_arg);
        logic signed [31:0] arg;
        arg = with_arg ? pick_argument() : $urandom;
        spec_q.push_back(make_item(c, arg, spec_q.size() == 0));
    endfunction

    function automatic void add_digits(int min_len);
        int n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 7) : $urandom_range(min_len, 3);
        repeat (n)
            add_char(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endfunction

    function automatic void build_spec();
        logic [7:0] flag_chars[5];
        string      conv_chars;
        int         width_kind;
        spec_q.delete();
        flag_chars = '{CH_MINUS, CH_PLUS, CH_SPACE, CH_HASH, CH_ZERO};
        conv_chars = "dioxXucsfeEgGpnl%";
        if ($urandom_range(0, 3) != 0)
            repeat ($urandom_range(1, 5))
                add_char(flag_chars[$urandom_range(0, 4)], 1'b0);
        width_kind = $urandom_range(0, 2);
        if (width_kind == 1)
            add_digits(1);
        else if (width_kind == 2)
            add_char(CH_STAR, 1'b1);
        if ($urandom_range(0, 4) < 3)
        begin
            add_char(CH_DOT, 1'b0);
            case ($urandom_range(0, 3))
                0: ;
                1: add_char(CH_STAR, 1'b1);
                2:
                begin
                    add_char(CH_MINUS, 1'b0);
                    add_digits(0);
                end
                default: add_digits(1);
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            add_char(8'($urandom_range(0, 255)), 1'b1);
        else
            add_char(conv_chars[$urandom_range(0, conv_chars.len() - 1)], 1'b0);
        // Random characters are added after the end of the spec.
        repeat ($urandom_range(0, 2))
            add_char(8'($urandom_range(0, 255)), 1'b1);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(in_t item);
        int gap;
        if (steady_items > 0)
            steady_items--;
        else
        begin
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_queue();
        foreach (spec_q[i])
            send_item(spec_q[i]);
    endtask

    task automatic drain_results();
        int n;
        in_valid <= 1'b0;
        n = 0;
        while (sb.pending_count() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        if (sb.pending_count() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_count()));
        @(negedge clk);
    endtask

    initial
    begin
        bit hold_done;
        bit pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        spec_q = '{
            // All five flags, a width with a zero digit, a precision, the end,
            // then a character after the end.
            make_item(CH_MINUS, 0, 1), make_item(CH_PLUS, 0, 0),
            make_item(CH_SPACE, 0, 0), make_item(CH_HASH, 0, 0),
            make_item(CH_ZERO, 0, 0), make_item("7", 0, 0),
            make_item(CH_ZERO, 0, 0), make_item(CH_DOT, 0, 0),
            make_item("5", 0, 0), make_item("d", 0, 0), make_item(8'hFF, -1, 0),
            // Most negative star width and a negative star precision.
            make_item(CH_STAR, 32'sh8000_0000, 1), make_item(CH_DOT, 0, 0),
            make_item(CH_STAR, -5, 0), make_item("s", 0, 0),
            // A dot with nothing after it, ended by a NUL character.
            make_item(CH_DOT, 0, 1), make_item(8'h00, 0, 0), make_item("x", 0, 0),
            // Minus zero precision.
            make_item(CH_DOT, 0, 1), make_item(CH_MINUS, 0, 0),
            make_item(CH_ZERO, 0, 0), make_item("f", 0, 0),
            // Largest star width, then a precision that overflows.
            make_item(CH_STAR, 32'sh7FFF_FFFF, 1), make_item(CH_DOT, 0, 0),
            make_item("9", 0, 0), make_item("9", 0, 0), make_item("9", 0, 0),
            make_item("9", 0, 0), make_item("9", 0, 0)
        };
        send_queue();
        drain_results();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (!hold_done && items_sent > 400)
            begin
                hold_done = 1'b1;
                steady_items = 40;
                hold_request = 1'b1;
            end
            if (!pause_done && items_sent > 750)
            begin
                pause_done = 1'b1;
                drain_results();
            end
            if ($urandom_range(0, 6) != 0)
                build_spec();
            else
            begin
                // Noise: random characters, mostly without a start mark.
                spec_q.delete();
                repeat ($urandom_range(1, 4))
                    spec_q.push_back(make_item(8'($urandom_range(0, 255)), pick_argument(),
                                               $urandom_range(0, 3) == 0));
            end
            send_queue();
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
